// ===== rtl/sarn_pkg.sv =====
// Shared constants, command codes and control/status structs for the recurrent net step.
`timescale 1ns / 1ps

package sarn_pkg;

  // Default hidden layer size
  localparam int HIDDEN_DEF = 4;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int WIDX_W   = 5;
  localparam int WEIGHT_W = 8;
  localparam int SAMPLE_W = 16;
  localparam int TGT_W    = 2;
  localparam int SUM_W    = 11;
  localparam int SIGN_W   = 2;
  localparam int ERR_W    = 2;

  // Widest weight address and neuron index over the supported range (HIDDEN up to 16)
  localparam int ADDR_W = 9;
  localparam int SEL_W  = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

  // Sign source of one accumulation term
  localparam logic [1:0] SRC_CTX = 2'd0;
  localparam logic [1:0] SRC_INP = 2'd1;
  localparam logic [1:0] SRC_HID = 2'd2;

  // Activation codes
  localparam logic signed [SIGN_W-1:0] SIGN_POS = 2'sb01;
  localparam logic signed [SIGN_W-1:0] SIGN_NEG = 2'sb11;

  // Controller to datapath
  typedef struct packed {
    logic              accept;
    logic              rd;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        src;
    logic [SEL_W-1:0]  sel;
    logic [SEL_W-1:0]  kidx;
    logic              first;
    logic              last_hid;
    logic              last_out;
  } sarn_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_full;
  } sarn_st_t;

endpackage

// ===== rtl/sarn_ctrl.sv =====
// Sequencer that walks the weight reads of one step and issues datapath commands.
`timescale 1ns / 1ps

module sarn_ctrl #(
  parameter int HIDDEN = sarn_pkg::HIDDEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [sarn_pkg::CMD_W-1:0]  in_cmd,
  output logic                        in_ready,
  input  sarn_pkg::sarn_st_t          st,
  output sarn_pkg::sarn_ctl_t         ctl
);
  import sarn_pkg::*;

  localparam int CW      = $clog2(HIDDEN + 1);
  localparam int IN_BASE = HIDDEN * HIDDEN;
  localparam int OUT_BASE = HIDDEN * HIDDEN + HIDDEN;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HID  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic          accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and counters
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_cmd == CMD_STEP) begin
          state_nxt = S_HID;
          k_nxt     = '0;
          j_nxt     = '0;
        end
      end
      S_HID: begin
        if (j_r == CW'(HIDDEN)) begin
          j_nxt = '0;
          if (k_r == CW'(HIDDEN - 1)) begin
            state_nxt = S_HOLD;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_HOLD: begin
        j_nxt = '0;
        if (!st.out_full) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (j_r == CW'(HIDDEN - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath command for this cycle
  always_comb begin
    ctl          = '0;
    ctl.accept   = accept;
    ctl.sel      = SEL_W'(j_r);
    ctl.kidx     = SEL_W'(k_r);
    case (state_r)
      S_HID: begin
        ctl.rd    = 1'b1;
        ctl.first = (j_r == '0);
        if (j_r == CW'(HIDDEN)) begin
          ctl.src      = SRC_INP;
          ctl.addr     = ADDR_W'(IN_BASE) + ADDR_W'(k_r);
          ctl.last_hid = 1'b1;
        end else begin
          ctl.src  = SRC_CTX;
          ctl.addr = ADDR_W'(j_r) * ADDR_W'(HIDDEN) + ADDR_W'(k_r);
        end
      end
      S_OUT: begin
        ctl.rd       = 1'b1;
        ctl.src      = SRC_HID;
        ctl.first    = (j_r == '0);
        ctl.addr     = ADDR_W'(OUT_BASE) + ADDR_W'(j_r);
        ctl.last_out = (j_r == CW'(HIDDEN - 1));
      end
      default: ctl.rd = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
    end
  end

`ifndef SYNTHESIS
  // Final output term is never issued while a result still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.last_out |-> !st.out_full)
    else $error("output term issued while result pending");

  // A step request starts the hidden pass
  a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_STEP) |=> (state_r == S_HID && k_r == '0 && j_r == '0))
    else $error("step did not start hidden pass");

  // After the last output term the sequencer is free again
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.last_out |=> in_ready)
    else $error("not idle after last output term");

  // Hidden pass reads the input weight only at the end of a neuron
  a_inp_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.rd && ctl.src == SRC_INP) |-> ctl.last_hid)
    else $error("input weight read out of place");
`endif

endmodule

// ===== rtl/sarn_dp.sv =====
// Weight store, context bits, shared accumulator and result register.
`timescale 1ns / 1ps

module sarn_dp #(
  parameter int HIDDEN = sarn_pkg::HIDDEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sarn_pkg::sarn_ctl_t                 ctl,
  output sarn_pkg::sarn_st_t                  st,
  input  logic [sarn_pkg::CMD_W-1:0]          in_cmd,
  input  logic [sarn_pkg::WIDX_W-1:0]         in_weight_index,
  input  logic signed [sarn_pkg::WEIGHT_W-1:0] in_weight_value,
  input  logic signed [sarn_pkg::SAMPLE_W-1:0] in_sample_input,
  input  logic signed [sarn_pkg::TGT_W-1:0]   in_target,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sarn_pkg::SUM_W-1:0]   out_sum,
  output logic signed [sarn_pkg::SIGN_W-1:0]  out_sign,
  output logic [sarn_pkg::ERR_W-1:0]          out_abs_error
);
  import sarn_pkg::*;

  localparam int NW    = HIDDEN * HIDDEN + 2 * HIDDEN;
  // Only the slots reachable through the index field are stored; the rest read zero
  localparam int SD    = (NW < (1 << WIDX_W)) ? NW : (1 << WIDX_W);
  localparam int SA_W  = $clog2(SD);
  localparam int IW    = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam int ACC_A = $clog2((HIDDEN + 1) * (1 << (WEIGHT_W - 1)) + 1) + 1;
  localparam int ACC_W = (ACC_A > SUM_W + 1) ? ACC_A : SUM_W + 1;
  localparam logic signed [ACC_W-1:0] S_MAX = ACC_W'((1 << (SUM_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] S_MIN = -ACC_W'(1 << (SUM_W - 1));

  logic signed [WEIGHT_W-1:0] mem [SD];
  logic [SD-1:0]              valid_r;
  logic [HIDDEN-1:0]          ctx_r;
  logic [HIDDEN-1:0]          nxt_r;
  logic                       in_pos_r;
  logic signed [TGT_W-1:0]    target_r;
  logic signed [WEIGHT_W-1:0] w_r;
  logic                       wv_r;
  sarn_ctl_t                  q_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       out_valid_r;
  logic signed [SUM_W-1:0]    out_sum_r;
  logic signed [SIGN_W-1:0]   out_sign_r;
  logic [ERR_W-1:0]           out_err_r;

  logic                       wr_hit, clr_hit, step_hit;
  logic                       rd_in;
  logic [SA_W-1:0]            rd_idx;
  logic                       sign_pos;
  logic signed [ACC_W-1:0]    term, term_s, acc_nxt;
  logic signed [SUM_W-1:0]    sat;
  logic signed [SIGN_W-1:0]   osign;
  logic signed [2:0]          diff;
  logic [2:0]                 diff_abs;
  logic                       fin;

  // Request decode
  assign wr_hit   = ctl.accept && in_cmd == CMD_WRITE &&
                    ({{(ADDR_W-WIDX_W){1'b0}}, in_weight_index} < ADDR_W'(NW));
  assign clr_hit  = ctl.accept && in_cmd == CMD_CLEAR;
  assign step_hit = ctl.accept && in_cmd == CMD_STEP;

  // Read address into the stored part
  assign rd_in  = ctl.addr < ADDR_W'(SD);
  assign rd_idx = rd_in ? ctl.addr[SA_W-1:0] : '0;

  // Weight memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[in_weight_index[SA_W-1:0]] <= in_weight_value;
    end
    if (ctl.rd) begin
      w_r <= mem[rd_idx];
    end
  end

  // Sign of the current term
  always_comb begin
    case (q_r.src)
      SRC_CTX: sign_pos = ctx_r[q_r.sel[IW-1:0]];
      SRC_INP: sign_pos = in_pos_r;
      SRC_HID: sign_pos = nxt_r[q_r.sel[IW-1:0]];
      default: sign_pos = 1'b0;
    endcase
  end

  // Shared accumulator
  always_comb begin
    term    = wv_r ? {{(ACC_W-WEIGHT_W){w_r[WEIGHT_W-1]}}, w_r} : '0;
    term_s  = sign_pos ? term : -term;
    acc_nxt = (q_r.first ? '0 : acc_r) + term_s;
  end

  // Output saturation, sign and error
  always_comb begin
    if (acc_nxt > S_MAX) begin
      sat = S_MAX[SUM_W-1:0];
    end else if (acc_nxt < S_MIN) begin
      sat = S_MIN[SUM_W-1:0];
    end else begin
      sat = acc_nxt[SUM_W-1:0];
    end
    osign    = (sat > 0) ? SIGN_POS : SIGN_NEG;
    diff     = {osign[SIGN_W-1], osign} - {target_r[TGT_W-1], target_r};
    diff_abs = diff[2] ? -diff : diff;
  end

  assign fin = q_r.rd && q_r.last_out;

  // Payload registers
  always_ff @(posedge clk) begin
    if (step_hit) begin
      in_pos_r <= !in_sample_input[SAMPLE_W-1] && (|in_sample_input);
      target_r <= in_target;
    end
    if (q_r.rd) begin
      acc_r <= acc_nxt;
    end
    if (q_r.rd && q_r.last_hid) begin
      nxt_r[q_r.kidx[IW-1:0]] <= (acc_nxt > 0);
    end
    if (fin) begin
      out_sum_r  <= sat;
      out_sign_r <= osign;
      out_err_r  <= diff_abs[ERR_W-1:0];
    end
  end

  // Control state: valid bits, context, pipeline tag, result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      ctx_r       <= '0;
      wv_r        <= 1'b0;
      q_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      q_r <= ctl;
      if (ctl.rd) begin
        wv_r <= rd_in && valid_r[rd_idx];
      end
      // A clear taken as the last term lands wins over the context update
      if (clr_hit) begin
        valid_r <= '0;
        ctx_r   <= '0;
      end else begin
        if (wr_hit) begin
          valid_r[in_weight_index[SA_W-1:0]] <= 1'b1;
        end
        if (fin) begin
          ctx_r <= nxt_r;
        end
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.out_full   = out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_sum       = out_sum_r;
  assign out_sign      = out_sign_r;
  assign out_abs_error = out_err_r;

`ifndef SYNTHESIS
  // A result is only produced by the last output term
  a_fin_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fin))
    else $error("result without final term");

  // Reported sign agrees with the reported sum
  a_sign_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_sum_r > 0) == (out_sign_r == SIGN_POS)))
    else $error("sign does not match sum");

  // A clear empties the store
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_hit |=> (valid_r == '0 && ctx_r == '0))
    else $error("clear left state behind");
`endif

endmodule

// ===== rtl/sign_activation_recurrent_net_step.sv =====
// Top level of the sign-activation recurrent network step.
`timescale 1ns / 1ps

// Channel | Ports                                              | Direction
// in      | in_valid/in_ready, cmd, weight_index, weight_value, | request in
//         | sample_input, target                               |
// out     | out_valid/out_ready, out_sum, out_sign, out_abs_error | result out
//
// Write and clear requests give no result. Every weight read of a step goes
// through the single read port of the weight store and one shared accumulator.
// A step result waits in the output register; the next request is taken meanwhile,
// and a later step stalls before its output pass until that register is free.
// Synchronous active-low reset clears weight valid bits, context and control.
module sign_activation_recurrent_net_step #(
  parameter int HIDDEN = sarn_pkg::HIDDEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sarn_pkg::CMD_W-1:0]           in_cmd,
  input  logic [sarn_pkg::WIDX_W-1:0]          in_weight_index,
  input  logic signed [sarn_pkg::WEIGHT_W-1:0] in_weight_value,
  input  logic signed [sarn_pkg::SAMPLE_W-1:0] in_sample_input,
  input  logic signed [sarn_pkg::TGT_W-1:0]    in_target,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sarn_pkg::SUM_W-1:0]    out_sum,
  output logic signed [sarn_pkg::SIGN_W-1:0]   out_sign,
  output logic [sarn_pkg::ERR_W-1:0]           out_abs_error
);
  import sarn_pkg::*;

  sarn_ctl_t ctl;
  sarn_st_t  st;

  sarn_ctrl #(.HIDDEN(HIDDEN)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  sarn_dp #(.HIDDEN(HIDDEN)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .st              (st),
    .in_cmd          (in_cmd),
    .in_weight_index (in_weight_index),
    .in_weight_value (in_weight_value),
    .in_sample_input (in_sample_input),
    .in_target       (in_target),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sum         (out_sum),
    .out_sign        (out_sign),
    .out_abs_error   (out_abs_error)
  );

endmodule
